// ----- hdl/vlos_pkg.sv -----
// Shared types and constants for the voxel line-of-sight unit.
// Depends on nothing; all files but vlos_occ_mem refer to it by scoped names.
package vlos_pkg;

  localparam int COORD_W   = 18;
  localparam int MAG_W     = 19;
  localparam int SQ_W      = 38;
  localparam int DIST_W    = 19;
  localparam int OFS_W     = 14;
  localparam int STEPS_W   = 10;
  localparam int NUM_W     = 23;
  localparam int PROD_W    = 42;
  localparam int CELL_W    = 13;
  localparam int POS_W     = 20;
  localparam int FRAC_W    = 12;
  localparam int DIVN_W    = 34;
  localparam int DREM_W    = 20;
  localparam int SREM_W    = 21;
  localparam int IDX_W     = 15;
  localparam int IDX_EXT_W = 24;
  localparam int IT_W      = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;

  localparam int ONE_CELL   = 4096;
  localparam int NEAR_SQ    = 16;
  localparam int SQRT_ITERS = 19;
  localparam int DIV_ITERS  = 34;

  localparam logic [OFS_W-1:0]   START_OFFSET_RST = 14'd1229;
  localparam logic [OFS_W-1:0]   END_OFFSET_RST   = 14'd1638;
  localparam logic [STEPS_W-1:0] MAX_STEPS_RST    = 10'd512;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_RAY   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_OFFSET = 2'd0,
    CFG_END_OFFSET   = 2'd1,
    CFG_MAX_STEPS    = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_SQ_CHK, ST_SQRT, ST_SPAN,
    ST_OFS_MUL, ST_DIV, ST_AXIS_SET, ST_WALK_A, ST_WALK_B, ST_RESP
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic sq_mul;
    logic sq_acc;
    logic sqrt_init;
    logic sqrt_step;
    logic span_set;
    logic ofs_mul;
    logic div_step;
    logic axis_set;
    logic walk_a;
    logic walk_b;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ray;
    logic near;
    logic sqrt_done;
    logic short_ray;
    logic div_done;
    logic axis_last;
    logic walk_stop;
    logic walk_end;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic                      req_type;
    logic [IDX_W-1:0]          cell_index;
    logic                      cell_solid;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } req_t;

  typedef struct packed {
    logic               reply_kind;
    logic               sight_clear;
    logic [STEPS_W-1:0] cells_checked;
  } rsp_t;

endpackage

// ----- hdl/vlos_if.sv -----
// Channel interfaces: request, response and configuration write.
// Depends on vlos_pkg for field widths.
interface vlos_req_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [vlos_pkg::IDX_W-1:0]         cell_index;
  logic                               cell_solid;
  logic signed [vlos_pkg::COORD_W-1:0] start_x;
  logic signed [vlos_pkg::COORD_W-1:0] start_y;
  logic signed [vlos_pkg::COORD_W-1:0] start_z;
  logic signed [vlos_pkg::COORD_W-1:0] target_x;
  logic signed [vlos_pkg::COORD_W-1:0] target_y;
  logic signed [vlos_pkg::COORD_W-1:0] target_z;
  modport source (output valid, req_type, cell_index, cell_solid, start_x, start_y, start_z,
                  target_x, target_y, target_z, input ready);
  modport sink (input valid, req_type, cell_index, cell_solid, start_x, start_y, start_z,
                target_x, target_y, target_z, output ready);
endinterface

interface vlos_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           reply_kind;
  logic                           sight_clear;
  logic [vlos_pkg::STEPS_W-1:0]   cells_checked;
  modport source (output valid, reply_kind, sight_clear, cells_checked, input ready);
  modport sink (input valid, reply_kind, sight_clear, cells_checked, output ready);
endinterface

interface vlos_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [vlos_pkg::CFG_IDX_W-1:0]  index;
  logic [vlos_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/vlos_occ_mem.sv -----
// Occupancy bitmap: one solid bit per cell, one write and one registered read port.
// Depends on nothing.
module vlos_occ_mem #(
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [2**AW];
  logic rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/vlos_ctrl.sv -----
// Sequencer for the line-of-sight unit: clearing pass, setup phases and cell walk.
// Depends on vlos_pkg for state, command and status types.
module vlos_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vlos_pkg::sts_t  sts,
  output vlos_pkg::cmd_t  cmd
);

  vlos_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vlos_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vlos_pkg::ST_CLEAR:    if (sts.clr_done) state_nxt = vlos_pkg::ST_IDLE;
      vlos_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sts.ray ? vlos_pkg::ST_SQ_MUL : vlos_pkg::ST_RESP;
      end
      vlos_pkg::ST_SQ_MUL:   state_nxt = vlos_pkg::ST_SQ_ACC;
      vlos_pkg::ST_SQ_ACC:   state_nxt = sts.axis_last ? vlos_pkg::ST_SQ_CHK : vlos_pkg::ST_SQ_MUL;
      vlos_pkg::ST_SQ_CHK:   state_nxt = sts.near ? vlos_pkg::ST_RESP : vlos_pkg::ST_SQRT;
      vlos_pkg::ST_SQRT:     if (sts.sqrt_done) state_nxt = vlos_pkg::ST_SPAN;
      vlos_pkg::ST_SPAN:     state_nxt = sts.short_ray ? vlos_pkg::ST_RESP : vlos_pkg::ST_OFS_MUL;
      vlos_pkg::ST_OFS_MUL:  state_nxt = vlos_pkg::ST_DIV;
      vlos_pkg::ST_DIV:      if (sts.div_done) state_nxt = vlos_pkg::ST_AXIS_SET;
      vlos_pkg::ST_AXIS_SET: begin
        state_nxt = sts.axis_last ? vlos_pkg::ST_WALK_A : vlos_pkg::ST_OFS_MUL;
      end
      vlos_pkg::ST_WALK_A:   state_nxt = sts.walk_stop ? vlos_pkg::ST_RESP : vlos_pkg::ST_WALK_B;
      vlos_pkg::ST_WALK_B:   state_nxt = sts.walk_end ? vlos_pkg::ST_RESP : vlos_pkg::ST_WALK_A;
      vlos_pkg::ST_RESP:     if (!sts.out_busy) state_nxt = vlos_pkg::ST_IDLE;
      default:               state_nxt = vlos_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      vlos_pkg::ST_CLEAR:    cmd.clr_step = 1'b1;
      vlos_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      vlos_pkg::ST_SQ_MUL:   cmd.sq_mul = 1'b1;
      vlos_pkg::ST_SQ_ACC:   cmd.sq_acc = 1'b1;
      vlos_pkg::ST_SQ_CHK:   cmd.sqrt_init = !sts.near;
      vlos_pkg::ST_SQRT:     cmd.sqrt_step = 1'b1;
      vlos_pkg::ST_SPAN:     cmd.span_set = 1'b1;
      vlos_pkg::ST_OFS_MUL:  cmd.ofs_mul = 1'b1;
      vlos_pkg::ST_DIV:      cmd.div_step = 1'b1;
      vlos_pkg::ST_AXIS_SET: cmd.axis_set = 1'b1;
      vlos_pkg::ST_WALK_A:   cmd.walk_a = !sts.walk_stop;
      vlos_pkg::ST_WALK_B:   cmd.walk_b = 1'b1;
      vlos_pkg::ST_RESP:     cmd.out_load = !sts.out_busy;
      default:               cmd = '0;
    endcase
  end

endmodule

// ----- hdl/vlos_dp.sv -----
// Datapath: squared length, square root, offset divider, DDA walk and result register.
// Depends on vlos_pkg and vlos_occ_mem.
module vlos_dp #(
  parameter int AXIS_CELLS_LOG2 = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vlos_pkg::cmd_t                    cmd,
  output vlos_pkg::sts_t                    sts,
  input  vlos_pkg::req_t                    in_req,
  input  logic [vlos_pkg::OFS_W-1:0]        start_offset,
  input  logic [vlos_pkg::OFS_W-1:0]        end_offset,
  input  logic [vlos_pkg::STEPS_W-1:0]      step_limit,
  input  logic                              out_ready,
  output logic                              out_valid,
  output vlos_pkg::rsp_t                    out_rsp
);

  localparam int AW = 3 * AXIS_CELLS_LOG2;
  localparam int CW = vlos_pkg::CELL_W;
  localparam int NW = vlos_pkg::NUM_W;
  localparam int PW = vlos_pkg::PROD_W;
  localparam logic signed [CW-1:0] AXIS_N = CW'(1 << AXIS_CELLS_LOG2);
  localparam logic [31:0] CELL_CNT = 32'(1 << AW);

  // per-axis setup state
  logic signed [vlos_pkg::COORD_W-1:0] s_r [3];
  logic [vlos_pkg::MAG_W-1:0]          mag_r [3];
  logic                                neg_r [3];
  logic                                act_r [3];
  logic signed [CW-1:0]                cell_r [3];
  logic [NW-1:0]                       num_r [3];
  logic [1:0]                          ax_r;

  logic [vlos_pkg::SQ_W-1:0]   sq_r, prod_r, sqv_r;
  logic [vlos_pkg::IT_W-1:0]   it_r;
  logic [vlos_pkg::DIST_W-1:0] root_r, span_r;
  logic [vlos_pkg::SREM_W-1:0] rem_r;
  logic [vlos_pkg::DIVN_W-1:0] div_n_r;
  logic [vlos_pkg::DREM_W-1:0] div_rem_r;
  logic [vlos_pkg::OFS_W-1:0]  q_r;

  logic [NW-1:0]                t_num_r;
  logic [vlos_pkg::MAG_W-1:0]   t_den_r;
  logic [vlos_pkg::STEPS_W-1:0] g_r, cnt_r;
  logic [PW-1:0] pt_r, qt_r, x01_r, x10_r, x02_r, x20_r, x12_r, x21_r;
  logic          inb_r, kind_r, clear_r;
  logic [AW-1:0] clr_cnt_r;

  logic           out_valid_r;
  vlos_pkg::rsp_t out_rsp_r;

  // memory ports
  logic                          mem_we, mem_wdata, mem_rdata, idx_ok;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [vlos_pkg::IDX_EXT_W-1:0] idx_ext;

  // combinational helpers
  logic signed [vlos_pkg::COORD_W-1:0] in_s [3];
  logic signed [vlos_pkg::COORD_W-1:0] in_t [3];
  logic signed [vlos_pkg::MAG_W-1:0]   in_d [3];
  logic [vlos_pkg::SREM_W+1:0]         sq_sh, sq_trial;
  logic [vlos_pkg::SREM_W-1:0]         dv_sh, dv_den;
  logic [vlos_pkg::OFS_W:0]            ofs_sum;
  logic signed [vlos_pkg::POS_W-1:0]   pos;
  logic [vlos_pkg::FRAC_W-1:0]         frac;
  logic                                e01, e02, e12, beyond, hit, inb;
  logic [1:0]                          k;

  assign in_s[0] = in_req.start_x;
  assign in_s[1] = in_req.start_y;
  assign in_s[2] = in_req.start_z;
  assign in_t[0] = in_req.target_x;
  assign in_t[1] = in_req.target_y;
  assign in_t[2] = in_req.target_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_d[i] = $signed({in_t[i][vlos_pkg::COORD_W-1], in_t[i]})
              - $signed({in_s[i][vlos_pkg::COORD_W-1], in_s[i]});
    end
  end

  assign idx_ext   = vlos_pkg::IDX_EXT_W'(in_req.cell_index);
  assign idx_ok    = 32'(in_req.cell_index) < CELL_CNT;
  assign mem_we    = cmd.clr_step || (cmd.load && in_req.req_type == vlos_pkg::REQ_WRITE && idx_ok);
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : idx_ext[AW-1:0];
  assign mem_wdata = cmd.clr_step ? 1'b0 : in_req.cell_solid;
  assign mem_raddr = {cell_r[2][AXIS_CELLS_LOG2-1:0], cell_r[1][AXIS_CELLS_LOG2-1:0],
                      cell_r[0][AXIS_CELLS_LOG2-1:0]};

  vlos_occ_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // square root digit and divider step
  assign sq_sh    = {rem_r, sqv_r[vlos_pkg::SQ_W-1 -: 2]};
  assign sq_trial = {2'b00, root_r, 2'b01};
  assign dv_sh    = {div_rem_r, div_n_r[vlos_pkg::DIVN_W-1]};
  assign dv_den   = {1'b0, root_r, 1'b0};
  assign ofs_sum  = {1'b0, start_offset} + {1'b0, end_offset};

  // start position on the current axis after skipping the start offset
  always_comb begin
    pos  = $signed({{2{s_r[ax_r][vlos_pkg::COORD_W-1]}}, s_r[ax_r]})
         + (neg_r[ax_r] ? -$signed({6'd0, q_r}) : $signed({6'd0, q_r}));
    frac = pos[vlos_pkg::FRAC_W-1:0];
  end

  // next crossing axis; y beats x and z beats both on a tie
  assign e01 = act_r[0] && (!act_r[1] || x01_r < x10_r);
  assign e02 = act_r[0] && (!act_r[2] || x02_r < x20_r);
  assign e12 = act_r[1] && (!act_r[2] || x12_r < x21_r);
  assign k   = e01 ? (e02 ? 2'd0 : 2'd2) : (e12 ? 2'd1 : 2'd2);

  assign inb = cell_r[0] >= 0 && cell_r[0] < AXIS_N && cell_r[1] >= 0 && cell_r[1] < AXIS_N
            && cell_r[2] >= 0 && cell_r[2] < AXIS_N;
  assign beyond = pt_r > qt_r;
  assign hit    = mem_rdata && inb_r;

  always_comb begin
    sts           = '0;
    sts.clr_done  = &clr_cnt_r;
    sts.ray       = in_req.req_type == vlos_pkg::REQ_RAY;
    sts.near      = sq_r <= vlos_pkg::SQ_W'(vlos_pkg::NEAR_SQ);
    sts.sqrt_done = it_r == vlos_pkg::IT_W'(vlos_pkg::SQRT_ITERS - 1);
    sts.short_ray = {1'b0, root_r} <= 20'(ofs_sum);
    sts.div_done  = it_r == vlos_pkg::IT_W'(vlos_pkg::DIV_ITERS - 1);
    sts.axis_last = ax_r == 2'd2;
    sts.walk_stop = g_r >= step_limit;
    sts.walk_end  = beyond || hit;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i]   <= in_s[i];
        mag_r[i] <= in_d[i] < 0 ? vlos_pkg::MAG_W'(-in_d[i]) : vlos_pkg::MAG_W'(in_d[i]);
        neg_r[i] <= in_d[i] < 0;
        act_r[i] <= in_d[i] != 0;
      end
      sq_r    <= '0;
      ax_r    <= '0;
      kind_r  <= in_req.req_type;
      clear_r <= 1'b1;
      cnt_r   <= '0;
    end
    if (cmd.sq_mul) prod_r <= vlos_pkg::SQ_W'(mag_r[ax_r] * mag_r[ax_r]);
    if (cmd.sq_acc) begin
      sq_r <= sq_r + prod_r;
      ax_r <= ax_r + 2'd1;
    end
    if (cmd.sqrt_init) begin
      sqv_r  <= sq_r;
      rem_r  <= '0;
      root_r <= '0;
      it_r   <= '0;
    end
    if (cmd.sqrt_step) begin
      if (sq_sh >= sq_trial) begin
        rem_r  <= vlos_pkg::SREM_W'(sq_sh - sq_trial);
        root_r <= {root_r[vlos_pkg::DIST_W-2:0], 1'b1};
      end else begin
        rem_r  <= vlos_pkg::SREM_W'(sq_sh);
        root_r <= {root_r[vlos_pkg::DIST_W-2:0], 1'b0};
      end
      sqv_r <= {sqv_r[vlos_pkg::SQ_W-3:0], 2'b00};
      it_r  <= it_r + 1'b1;
    end
    if (cmd.span_set) begin
      span_r  <= vlos_pkg::DIST_W'({1'b0, root_r} - 20'(ofs_sum));
      ax_r    <= '0;
      t_num_r <= '0;
      t_den_r <= vlos_pkg::MAG_W'(1);
      g_r     <= '0;
    end
    if (cmd.ofs_mul) begin
      div_n_r   <= {33'(mag_r[ax_r] * start_offset), 1'b0} + vlos_pkg::DIVN_W'(root_r);
      div_rem_r <= '0;
      q_r       <= '0;
      it_r      <= '0;
    end
    if (cmd.div_step) begin
      if (dv_sh >= dv_den) begin
        div_rem_r <= vlos_pkg::DREM_W'(dv_sh - dv_den);
        q_r       <= {q_r[vlos_pkg::OFS_W-2:0], 1'b1};
      end else begin
        div_rem_r <= vlos_pkg::DREM_W'(dv_sh);
        q_r       <= {q_r[vlos_pkg::OFS_W-2:0], 1'b0};
      end
      div_n_r <= {div_n_r[vlos_pkg::DIVN_W-2:0], 1'b0};
      it_r    <= it_r + 1'b1;
    end
    if (cmd.axis_set) begin
      cell_r[ax_r] <= CW'(pos >>> vlos_pkg::FRAC_W);
      if (neg_r[ax_r]) begin
        num_r[ax_r] <= NW'(frac);
      end else if (act_r[ax_r]) begin
        num_r[ax_r] <= NW'(vlos_pkg::ONE_CELL) - NW'(frac);
      end else begin
        num_r[ax_r] <= '0;
      end
      ax_r <= ax_r + 2'd1;
    end
    if (cmd.walk_a) begin
      pt_r  <= PW'(t_num_r * root_r);
      qt_r  <= PW'(span_r * t_den_r);
      x01_r <= PW'(num_r[0] * mag_r[1]);
      x10_r <= PW'(num_r[1] * mag_r[0]);
      x02_r <= PW'(num_r[0] * mag_r[2]);
      x20_r <= PW'(num_r[2] * mag_r[0]);
      x12_r <= PW'(num_r[1] * mag_r[2]);
      x21_r <= PW'(num_r[2] * mag_r[1]);
      inb_r <= inb;
    end
    if (cmd.walk_b && !beyond) begin
      cnt_r <= cnt_r + 1'b1;
      if (hit) begin
        clear_r <= 1'b0;
      end else begin
        t_num_r  <= num_r[k];
        t_den_r  <= mag_r[k];
        num_r[k] <= num_r[k] + NW'(vlos_pkg::ONE_CELL);
        cell_r[k] <= neg_r[k] ? cell_r[k] - CW'(1) : cell_r[k] + CW'(1);
        g_r      <= g_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_rsp_r.reply_kind    <= kind_r;
      out_rsp_r.sight_clear   <= kind_r && clear_r;
      out_rsp_r.cells_checked <= kind_r ? cnt_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ----- hdl/voxel_line_of_sight_unit.sv -----
// Top level of the voxel line-of-sight unit: configuration registers, sequencer, datapath.
// Depends on vlos_pkg, vlos_if, vlos_ctrl and vlos_dp.
//
//  channel | dir | handshake     | carries
//  in_ch   | in  | valid/ready   | cell write or ray test item
//  out_ch  | out | valid/ready   | one reply item per request
//  cfg_ch  | in  | valid/ready   | register index and write data
//
// A write item goes to its reply once accepted; a ray first runs its setup after acceptance
// (squared length, near check, root, span check, three offset divisions with their
// multiply and axis set), then reads each walked cell from the occupancy memory.
// After reset a clearing pass over all 2^(3*AXIS_CELLS_LOG2) cells (32768 by default)
// empties the map; in_ch.ready stays low throughout. Configuration is taken at any time.
// A reply not yet taken holds the next reply back; in_ch.ready is high only when idle.
module voxel_line_of_sight_unit #(
  parameter int AXIS_CELLS_LOG2 = 5,
  parameter int STEP_LIMIT_MAX  = 1023
) (
  input logic        clk,
  input logic        rst_n,
  vlos_req_if.sink   in_ch,
  vlos_rsp_if.source out_ch,
  vlos_cfg_if.sink   cfg_ch
);

  localparam logic [11:0] STEP_CAP = 12'(STEP_LIMIT_MAX);

  logic [vlos_pkg::OFS_W-1:0]   start_offset_r, end_offset_r;
  logic [vlos_pkg::STEPS_W-1:0] max_steps_r, step_limit;
  vlos_pkg::cmd_t cmd;
  vlos_pkg::sts_t sts;
  vlos_pkg::req_t in_req;
  vlos_pkg::rsp_t out_rsp;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_offset_r <= vlos_pkg::START_OFFSET_RST;
      end_offset_r   <= vlos_pkg::END_OFFSET_RST;
      max_steps_r    <= vlos_pkg::MAX_STEPS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        vlos_pkg::CFG_START_OFFSET: start_offset_r <= cfg_ch.data;
        vlos_pkg::CFG_END_OFFSET:   end_offset_r   <= cfg_ch.data;
        vlos_pkg::CFG_MAX_STEPS:    max_steps_r    <= cfg_ch.data[vlos_pkg::STEPS_W-1:0];
        default:                    max_steps_r    <= max_steps_r;
      endcase
    end
  end

  assign step_limit = ({2'b00, max_steps_r} < STEP_CAP) ? max_steps_r
                                                        : STEP_CAP[vlos_pkg::STEPS_W-1:0];

  assign in_req.req_type   = in_ch.req_type;
  assign in_req.cell_index = in_ch.cell_index;
  assign in_req.cell_solid = in_ch.cell_solid;
  assign in_req.start_x    = in_ch.start_x;
  assign in_req.start_y    = in_ch.start_y;
  assign in_req.start_z    = in_ch.start_z;
  assign in_req.target_x   = in_ch.target_x;
  assign in_req.target_y   = in_ch.target_y;
  assign in_req.target_z   = in_ch.target_z;

  vlos_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vlos_dp #(.AXIS_CELLS_LOG2(AXIS_CELLS_LOG2)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_req       (in_req),
    .start_offset (start_offset_r),
    .end_offset   (end_offset_r),
    .step_limit   (step_limit),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_rsp      (out_rsp)
  );

  assign out_ch.reply_kind    = out_rsp.reply_kind;
  assign out_ch.sight_clear   = out_rsp.sight_clear;
  assign out_ch.cells_checked = out_rsp.cells_checked;

  a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.reply_kind |-> out_ch.cells_checked <= step_limit)
    else $error("ray reply examined more cells than the step limit");

  a_write_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.reply_kind |-> !out_ch.sight_clear && out_ch.cells_checked == '0)
    else $error("write reply carries ray fields");

  a_blocked_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.reply_kind && !out_ch.sight_clear |-> out_ch.cells_checked != '0)
    else $error("blocked answer without an examined cell");

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ch.ready)
    else $error("request taken during the clearing pass");

endmodule
